// File: sv/aabbxf_pkg.sv
// ----------------------------------------------------------------------------
// aabbxf_pkg
// Shared types and constants for the box transform core: register map,
// coefficient packing and pipeline stage enables.
// ----------------------------------------------------------------------------
package aabbxf_pkg;

  // coefficient packing: three signed values per linear row register
  localparam int COEF_WIDTH      = 16;
  localparam int ROW_COEFS       = 3;
  localparam int CFG_WIDTH       = 48;
  localparam int SHIFT_WIDTH     = 32;
  localparam int CFG_INDEX_WIDTH = 3;

  // configuration register map
  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_ROW_X   = 3'd0,
    REG_ROW_Y   = 3'd1,
    REG_ROW_Z   = 3'd2,
    REG_SHIFT_X = 3'd3,
    REG_SHIFT_Y = 3'd4,
    REG_SHIFT_Z = 3'd5
  } cfg_reg_t;

  // per-stage advance enables handed to the row units
  typedef struct packed {
    logic prod;
    logic sum;
  } stage_en_t;

endpackage

// File: sv/aabbxf_box_if.sv
// ----------------------------------------------------------------------------
// aabbxf_box_if
// Input channel: one box given as min and max corners, valid/ready handshake.
// ----------------------------------------------------------------------------
interface aabbxf_box_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] lo_x;
  logic signed [COORD_WIDTH-1:0] lo_y;
  logic signed [COORD_WIDTH-1:0] lo_z;
  logic signed [COORD_WIDTH-1:0] hi_x;
  logic signed [COORD_WIDTH-1:0] hi_y;
  logic signed [COORD_WIDTH-1:0] hi_z;

  modport source (output valid, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, input ready);
  modport sink   (input valid, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, output ready);
endinterface

// File: sv/aabbxf_res_if.sv
// ----------------------------------------------------------------------------
// aabbxf_res_if
// Result channel: transformed box corners and saturation flag.
// ----------------------------------------------------------------------------
interface aabbxf_res_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] new_lo_x;
  logic signed [COORD_WIDTH-1:0] new_lo_y;
  logic signed [COORD_WIDTH-1:0] new_lo_z;
  logic signed [COORD_WIDTH-1:0] new_hi_x;
  logic signed [COORD_WIDTH-1:0] new_hi_y;
  logic signed [COORD_WIDTH-1:0] new_hi_z;
  logic                          clipped;

  modport source (output valid, new_lo_x, new_lo_y, new_lo_z,
                  new_hi_x, new_hi_y, new_hi_z, clipped, input ready);
  modport sink   (input valid, new_lo_x, new_lo_y, new_lo_z,
                  new_hi_x, new_hi_y, new_hi_z, clipped, output ready);
endinterface

// File: sv/aabb_affine_transform_core.sv
// ----------------------------------------------------------------------------
// aabb_affine_transform_core
// Transforms an axis-aligned box by a 3x4 affine matrix using the
// center/extents form, with saturating Q16.16 outputs.
// ----------------------------------------------------------------------------
// throughput: one box per cycle while the result side is ready; stages are
//   center/extents, products, row sums, saturate; each stage holds its data
//   while the next is stalled
// reset: clears all stage valid bits, loads the identity matrix and a zero
//   translation
module aabb_affine_transform_core #(
  parameter int COORD_WIDTH    = 32,
  parameter int COEF_FRAC_BITS = 12
) (
  input  logic                                       clk,
  input  logic                                       rst,
  aabbxf_box_if.sink                                 box,
  aabbxf_res_if.source                               result,
  input  logic                                       cfg_we,
  input  logic [aabbxf_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
  input  logic [aabbxf_pkg::CFG_WIDTH-1:0]           cfg_data
);

  localparam int W     = COORD_WIDTH;
  localparam int NR    = aabbxf_pkg::ROW_COEFS;
  localparam int PW    = COORD_WIDTH + aabbxf_pkg::COEF_WIDTH + 1;
  localparam int SW    = COORD_WIDTH + 24;
  localparam int CFW   = aabbxf_pkg::CFG_WIDTH;
  localparam int SHW   = aabbxf_pkg::SHIFT_WIDTH;
  localparam int CW    = aabbxf_pkg::COEF_WIDTH;

  localparam logic signed [W-1:0] COORD_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] COORD_MIN = {1'b1, {(W-1){1'b0}}};

  // configuration registers
  logic [CFW-1:0]          row_lin [NR];
  logic signed [SHW-1:0]   shift   [NR];

  // pipeline control
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;
  aabbxf_pkg::stage_en_t en;

  // stage 1 data
  logic signed [W-1:0] ctr [NR];
  logic signed [W-1:0] ext [NR];
  logic signed [W-1:0] lo_in [NR];
  logic signed [W-1:0] hi_in [NR];
  logic signed [W:0]   sum_in [NR];
  logic signed [W:0]   dif_in [NR];

  // stage 3 data
  logic signed [SW-1:0] new_ctr [NR];
  logic signed [SW-1:0] new_ext [NR];

  // stage 4 data
  logic signed [SW-1:0] lo_full [NR];
  logic signed [SW-1:0] hi_full [NR];
  logic                 lo_ovf  [NR];
  logic                 hi_ovf  [NR];
  logic signed [W-1:0]  lo_sat  [NR];
  logic signed [W-1:0]  hi_sat  [NR];
  logic                 clip_any;

  function automatic logic ovf_of(input logic signed [SW-1:0] v);
    return !((&v[SW-1:W-1]) || !(|v[SW-1:W-1]));
  endfunction

  function automatic logic signed [W-1:0] sat_of(input logic signed [SW-1:0] v);
    if (ovf_of(v)) begin
      return v[SW-1] ? COORD_MIN : COORD_MAX;
    end
    return v[W-1:0];
  endfunction

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      row_lin[0] <= CFW'(1) << COEF_FRAC_BITS;
      row_lin[1] <= CFW'(1) << (COEF_FRAC_BITS + CW);
      row_lin[2] <= CFW'(1) << (COEF_FRAC_BITS + 2*CW);
      shift[0]   <= '0;
      shift[1]   <= '0;
      shift[2]   <= '0;
    end else if (cfg_we) begin
      unique case (aabbxf_pkg::cfg_reg_t'(cfg_index))
        aabbxf_pkg::REG_ROW_X:   row_lin[0] <= cfg_data;
        aabbxf_pkg::REG_ROW_Y:   row_lin[1] <= cfg_data;
        aabbxf_pkg::REG_ROW_Z:   row_lin[2] <= cfg_data;
        aabbxf_pkg::REG_SHIFT_X: shift[0]   <= cfg_data[SHW-1:0];
        aabbxf_pkg::REG_SHIFT_Y: shift[1]   <= cfg_data[SHW-1:0];
        aabbxf_pkg::REG_SHIFT_Z: shift[2]   <= cfg_data[SHW-1:0];
        default: ;
      endcase
    end
  end

  // ready chain: a stage advances when it is empty or its successor advances
  assign rdy4      = !v4 || result.ready;
  assign rdy3      = !v3 || rdy4;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign box.ready = rdy1;
  assign en.prod   = rdy2;
  assign en.sum    = rdy3;

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= box.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // center and extents, floor halving of sum and difference
  always_comb begin
    lo_in[0] = box.lo_x;
    lo_in[1] = box.lo_y;
    lo_in[2] = box.lo_z;
    hi_in[0] = box.hi_x;
    hi_in[1] = box.hi_y;
    hi_in[2] = box.hi_z;
    for (int i = 0; i < NR; i++) begin
      sum_in[i] = (W+1)'(hi_in[i]) + (W+1)'(lo_in[i]);
      dif_in[i] = (W+1)'(hi_in[i]) - (W+1)'(lo_in[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      for (int i = 0; i < NR; i++) begin
        ctr[i] <= sum_in[i][W:1];
        ext[i] <= dif_in[i][W:1];
      end
    end
  end

  // one row unit per output axis
  for (genvar r = 0; r < NR; r++) begin : g_row
    aabbxf_row #(
      .COORD_WIDTH    (COORD_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS),
      .PROD_WIDTH     (PW),
      .SUM_WIDTH      (SW)
    ) u_row (
      .clk     (clk),
      .en      (en),
      .ctr     (ctr),
      .ext     (ext),
      .coefs   (row_lin[r]),
      .shift   (shift[r]),
      .new_ctr (new_ctr[r]),
      .new_ext (new_ext[r])
    );
  end

  // corners and saturation
  always_comb begin
    clip_any = 1'b0;
    for (int i = 0; i < NR; i++) begin
      lo_full[i] = new_ctr[i] - new_ext[i];
      hi_full[i] = new_ctr[i] + new_ext[i];
      lo_ovf[i]  = ovf_of(lo_full[i]);
      hi_ovf[i]  = ovf_of(hi_full[i]);
      lo_sat[i]  = sat_of(lo_full[i]);
      hi_sat[i]  = sat_of(hi_full[i]);
      clip_any   = clip_any | lo_ovf[i] | hi_ovf[i];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rdy4) begin
      result.new_lo_x <= lo_sat[0];
      result.new_lo_y <= lo_sat[1];
      result.new_lo_z <= lo_sat[2];
      result.new_hi_x <= hi_sat[0];
      result.new_hi_y <= hi_sat[1];
      result.new_hi_z <= hi_sat[2];
      result.clipped  <= clip_any;
    end
  end

  assign result.valid = v4;

  // accepted transaction lands in stage one
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    box.valid && box.ready |=> v1)
    else $error("accepted transaction missing from first stage");

  // a stalled sum stage keeps its item and data
  a_sum_hold: assert property (@(posedge clk) disable iff (rst)
    v3 && !rdy3 |=> v3 && $stable(new_ctr[0]) && $stable(new_ext[0]))
    else $error("sum stage lost data under stall");

  // delivered result with nothing behind it is not repeated
  a_no_repeat: assert property (@(posedge clk) disable iff (rst)
    v4 && result.ready && !v3 |=> !result.valid)
    else $error("result repeated");

  // full pipeline under stall refuses input
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    v1 && v2 && v3 && v4 && !result.ready |-> !box.ready)
    else $error("input accepted into a full stalled pipeline");

endmodule

// File: sv/aabbxf_row.sv
// ----------------------------------------------------------------------------
// aabbxf_row
// One matrix row: multiplies center by the coefficients and extents by their
// magnitudes, sums truncated products into new center (+shift) and new extent.
// ----------------------------------------------------------------------------
module aabbxf_row #(
  parameter int COORD_WIDTH    = 32,
  parameter int COEF_FRAC_BITS = 12,
  parameter int PROD_WIDTH     = 49,
  parameter int SUM_WIDTH      = 56
) (
  input  logic                                           clk,
  input  aabbxf_pkg::stage_en_t                          en,
  input  logic signed [COORD_WIDTH-1:0]                  ctr [aabbxf_pkg::ROW_COEFS],
  input  logic signed [COORD_WIDTH-1:0]                  ext [aabbxf_pkg::ROW_COEFS],
  input  logic [aabbxf_pkg::CFG_WIDTH-1:0]               coefs,
  input  logic signed [aabbxf_pkg::SHIFT_WIDTH-1:0]      shift,
  output logic signed [SUM_WIDTH-1:0]                    new_ctr,
  output logic signed [SUM_WIDTH-1:0]                    new_ext
);

  localparam int CW = aabbxf_pkg::COEF_WIDTH;

  logic signed [CW-1:0]         m     [aabbxf_pkg::ROW_COEFS];
  logic signed [CW:0]           m_abs [aabbxf_pkg::ROW_COEFS];
  logic signed [PROD_WIDTH-1:0] pc    [aabbxf_pkg::ROW_COEFS];
  logic signed [PROD_WIDTH-1:0] pe    [aabbxf_pkg::ROW_COEFS];
  logic signed [SUM_WIDTH-1:0]  tc    [aabbxf_pkg::ROW_COEFS];
  logic signed [SUM_WIDTH-1:0]  te    [aabbxf_pkg::ROW_COEFS];

  // unpack coefficients and take magnitudes (17 bits, so -32768 maps to 32768)
  always_comb begin
    for (int j = 0; j < aabbxf_pkg::ROW_COEFS; j++) begin
      m[j]     = coefs[j*CW +: CW];
      m_abs[j] = m[j][CW-1] ? -((CW+1)'(m[j])) : (CW+1)'(m[j]);
    end
  end

  // product stage
  always_ff @(posedge clk) begin
    if (en.prod) begin
      for (int j = 0; j < aabbxf_pkg::ROW_COEFS; j++) begin
        pc[j] <= PROD_WIDTH'(ctr[j]) * PROD_WIDTH'(m[j]);
        pe[j] <= PROD_WIDTH'(ext[j]) * PROD_WIDTH'(m_abs[j]);
      end
    end
  end

  // truncate each product to Q16.16 by arithmetic shift
  always_comb begin
    for (int j = 0; j < aabbxf_pkg::ROW_COEFS; j++) begin
      tc[j] = SUM_WIDTH'(pc[j] >>> COEF_FRAC_BITS);
      te[j] = SUM_WIDTH'(pe[j] >>> COEF_FRAC_BITS);
    end
  end

  // sum stage
  always_ff @(posedge clk) begin
    if (en.sum) begin
      new_ctr <= SUM_WIDTH'(shift) + tc[0] + tc[1] + tc[2];
      new_ext <= te[0] + te[1] + te[2];
    end
  end

endmodule
